[design/shot_pkg.sv]
// ----------------------------------------------------------------------------
// shot_pkg: shared types and constants
// Frame geometry and the frame record passed from front to back.
// ----------------------------------------------------------------------------
package shot_pkg;

	localparam int NUM_CH    = 6;
	localparam int FRAME_LEN = 48;
	localparam int SAMPLE_W  = 12;
	localparam int SUM_W     = 15;
	localparam int POS_W     = 6;
	localparam int CH_W      = 3;

	localparam logic [POS_W-1:0]    POS_LAST   = POS_W'(FRAME_LEN - 1);
	localparam logic [CH_W-1:0]     CH_LAST    = CH_W'(NUM_CH - 1);
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

	// one finished frame: per-channel averages, and whether it sets the baseline
	typedef struct packed {
		logic                             base;
		logic [NUM_CH-1:0][SAMPLE_W-1:0]  avg;
	} frame_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[design/six_axis_hall_offset_transform_top.sv]
// ----------------------------------------------------------------------------
// six_axis_hall_offset_transform_top: six-axis hall offset transform
// Averages are registered in the queue, the pair stage, then the outputs.
// Throughput: one item per cycle while not stalled; one result per 48-item
// frame, none for the first (baseline) frame after reset.
// Input stalls only on a frame's last item while both queue slots are full.
// Reset clears counters, sums, queue and valids; the baseline is rebuilt.
// ----------------------------------------------------------------------------
module six_axis_hall_offset_transform_top
	import shot_pkg::*;
#(
	parameter int AVG_SHIFT = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  trans_z,
	output logic signed [14:0]  trans_y,
	output logic signed [14:0]  trans_x,
	output logic signed [15:0]  rot_z,
	output logic signed [14:0]  rot_x,
	output logic signed [14:0]  rot_y
);

	q_stat_t    q_stat;
	logic       push;
	logic       pop;
	frame_rec_t push_rec;
	frame_rec_t head;

	shot_front #(
		.AVG_SHIFT(AVG_SHIFT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample   (sample),
		.q_stat   (q_stat),
		.push     (push),
		.push_rec (push_rec)
	);

	shot_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	shot_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.trans_z   (trans_z),
		.trans_y   (trans_y),
		.trans_x   (trans_x),
		.rot_z     (rot_z),
		.rot_x     (rot_x),
		.rot_y     (rot_y)
	);

endmodule

[design/shot_front.sv]
// ----------------------------------------------------------------------------
// shot_front: sample accumulator
// Sums each channel over a frame and pushes the channel averages at frame end.
// ----------------------------------------------------------------------------
module shot_front
	import shot_pkg::*;
#(
	parameter int AVG_SHIFT = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SAMPLE_W-1:0] sample,
	input  q_stat_t             q_stat,
	output logic                push,
	output frame_rec_t          push_rec
);

	logic [POS_W-1:0]              pos_q;
	logic [CH_W-1:0]               ch_q;
	logic                          base_done_q;
	logic [NUM_CH-1:0][SUM_W-1:0]  sums_q;
	logic [NUM_CH-1:0][SUM_W-1:0]  sum_in;
	logic                          accept;
	logic                          frame_end;

	assign in_stall  = q_stat.full && (pos_q == POS_LAST);
	assign accept    = in_valid && !in_stall;
	assign frame_end = accept && (pos_q == POS_LAST);
	assign push      = frame_end;

	always_comb begin
		logic [SUM_W-1:0] shifted;
		shifted       = '0;
		push_rec.base = !base_done_q;
		for (int i = 0; i < NUM_CH; i++) begin
			sum_in[i] = sums_q[i] +
				((ch_q == CH_W'(i)) ? SUM_W'(sample) : SUM_W'(0));
			shifted = sum_in[i] >> AVG_SHIFT;
			// small shifts can push the average past the sample range
			push_rec.avg[i] = (shifted > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX
				: shifted[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			ch_q        <= '0;
			base_done_q <= 1'b0;
			sums_q      <= '0;
		end else if (accept) begin
			if (frame_end) begin
				pos_q       <= '0;
				ch_q        <= '0;
				base_done_q <= 1'b1;
				sums_q      <= '0;
			end else begin
				pos_q  <= pos_q + POS_W'(1);
				ch_q   <= (ch_q == CH_LAST) ? '0 : ch_q + CH_W'(1);
				sums_q <= sum_in;
			end
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LAST)
		else $error("frame position out of range");

	a_ch_tracks_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == '0) |-> (ch_q == '0))
		else $error("channel counter out of step with frame start");

endmodule

[design/shot_queue.sv]
// ----------------------------------------------------------------------------
// shot_queue: two-entry frame queue
// Decouples the accumulator from the transform and output stages.
// ----------------------------------------------------------------------------
module shot_queue
	import shot_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frame_rec_t push_rec,
	input  logic       pop,
	output frame_rec_t head,
	output q_stat_t    q_stat
);

	frame_rec_t  mem_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;

	assign head         = mem_q[rd_q];
	assign q_stat.full  = (cnt_q == 2'd2);
	assign q_stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && q_stat.full))
		else $error("frame queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty))
		else $error("frame queue underflow");

endmodule

[design/shot_back.sv]
// ----------------------------------------------------------------------------
// shot_back: offset transform
// Holds the baseline, forms pair sums and differences, then the six axes.
// ----------------------------------------------------------------------------
module shot_back
	import shot_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  frame_rec_t         head,
	input  q_stat_t            q_stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] trans_z,
	output logic signed [14:0] trans_y,
	output logic signed [14:0] trans_x,
	output logic signed [15:0] rot_z,
	output logic signed [14:0] rot_x,
	output logic signed [14:0] rot_y
);

	localparam int PW = SAMPLE_W + 2;
	localparam int XW = PW + 3;

	logic [NUM_CH-1:0][SAMPLE_W-1:0] base_q;
	logic                            valid_s1;
	logic signed [PW-1:0]            c1_s1, m1_s1, c2_s1, m2_s1, c3_s1, m3_s1;
	logic signed [PW-2:0]            d [NUM_CH];
	logic                            adv_s2;
	logic                            adv_s1;

	function automatic logic signed [XW-1:0] sx(input logic signed [PW-1:0] v);
		return {{(XW-PW){v[PW-1]}}, v};
	endfunction

	// signed halving, truncated toward zero
	function automatic logic signed [XW-1:0] hv(input logic signed [PW-1:0] v);
		logic [PW-1:0] t;
		t = v + PW'(v[PW-1]);
		return {{(XW-PW+1){t[PW-1]}}, t[PW-1:1]};
	endfunction

	assign adv_s2 = !out_valid || !out_stall;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pop    = !q_stat.empty && adv_s1;

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			d[i] = $signed({1'b0, base_q[i]}) - $signed({1'b0, head.avg[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.base) begin
			base_q <= head.avg;
		end
		if (adv_s1) begin
			c1_s1 <= {d[0][PW-2], d[0]} + {d[1][PW-2], d[1]};
			m1_s1 <= {d[0][PW-2], d[0]} - {d[1][PW-2], d[1]};
			c2_s1 <= {d[2][PW-2], d[2]} + {d[3][PW-2], d[3]};
			m2_s1 <= {d[2][PW-2], d[2]} - {d[3][PW-2], d[3]};
			c3_s1 <= {d[4][PW-2], d[4]} + {d[5][PW-2], d[5]};
			m3_s1 <= {d[4][PW-2], d[4]} - {d[5][PW-2], d[5]};
		end
	end

	always_ff @(posedge clk) begin
		logic signed [XW-1:0] tz, ty, tx, rz, rx, ry;
		tz = sx(c1_s1) + sx(c2_s1) + sx(c3_s1);
		ty = sx(m3_s1) - sx(m1_s1);
		tx = hv(m1_s1) + hv(m3_s1) - sx(m2_s1);
		rz = sx(m1_s1) + sx(m2_s1) + sx(m3_s1);
		rx = hv(c1_s1) - sx(c2_s1) + hv(c3_s1);
		ry = sx(c3_s1) - sx(c1_s1);
		if (adv_s2 && valid_s1) begin
			trans_z <= tz[15:0];
			trans_y <= ty[14:0];
			trans_x <= tx[14:0];
			rot_z   <= rz[15:0];
			rot_x   <= rx[14:0];
			rot_y   <= ry[14:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= pop && !head.base;
			end
			if (adv_s2) begin
				out_valid <= valid_s1;
			end
		end
	end

	a_base_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.base) |=> !valid_s1)
		else $error("baseline frame produced a result");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: six-axis hall offset transform testbench
// The sender streams 48-item frames of hall samples in bursts with random
// gaps. A class tracks channel sums and the baseline and predicts each
// frame's six axes. The receiver stalls on a pattern of its own, and every
// result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb
	import shot_pkg::*;
();

	localparam int AVG_SHIFT = 3;
	localparam int MAX_SHOWN = 10;
	localparam int TOP_LVL   = (1 << SAMPLE_W) - 1;

	typedef struct packed {
		logic signed [15:0] tz;
		logic signed [14:0] ty;
		logic signed [14:0] tx;
		logic signed [15:0] rz;
		logic signed [14:0] rx;
		logic signed [14:0] ry;
	} axes_t;

	typedef enum int {FRAME_NOISE, FRAME_EXTREME, FRAME_NEAR_BASE, FRAME_LEVELS} frame_kind_t;
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_kind_t;

	class hall_axes_calc;
		logic [SUM_W-1:0]    ch_sum [NUM_CH];
		logic [SAMPLE_W-1:0] base_avg [NUM_CH];
		int                  pos;
		bit                  base_set;
		axes_t               axes_due [$];
		int                  mismatches;

		function new();
			foreach (ch_sum[i]) begin
				ch_sum[i]   = '0;
				base_avg[i] = '0;
			end
			pos        = 0;
			base_set   = 1'b0;
			mismatches = 0;
		endfunction

		// average saturates at full scale, only reachable with a small shift
		function int avg_of(logic [SUM_W-1:0] s);
			int a;
			a = int'(s >> AVG_SHIFT);
			return (a > int'(SAMPLE_MAX)) ? int'(SAMPLE_MAX) : a;
		endfunction

		function void take_sample(logic [SAMPLE_W-1:0] s);
			int    d [NUM_CH];
			int    c1, m1, c2, m2, c3, m3;
			axes_t a;
			ch_sum[pos % NUM_CH] += s;
			if (pos < FRAME_LEN - 1) begin
				pos++;
				return;
			end
			pos = 0;
			if (!base_set) begin
				foreach (ch_sum[i]) begin
					base_avg[i] = SAMPLE_W'(avg_of(ch_sum[i]));
					ch_sum[i]   = '0;
				end
				base_set = 1'b1;
				return;
			end
			foreach (ch_sum[i]) begin
				d[i]      = int'(base_avg[i]) - avg_of(ch_sum[i]);
				ch_sum[i] = '0;
			end
			c1 = d[0] + d[1];
			m1 = d[0] - d[1];
			c2 = d[2] + d[3];
			m2 = d[2] - d[3];
			c3 = d[4] + d[5];
			m3 = d[4] - d[5];
			// integer division truncates toward zero, as the halving must
			a.tz = 16'(c1 + c2 + c3);
			a.ty = 15'(m3 - m1);
			a.tx = 15'(m1 / 2 + m3 / 2 - m2);
			a.rz = 16'(m1 + m2 + m3);
			a.rx = 15'(c1 / 2 - c2 + c3 / 2);
			a.ry = 15'(c3 - c1);
			axes_due.push_back(a);
		endfunction

		function void match_axes(axes_t got);
			axes_t want;
			if (axes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: result with none due: tz=%0d ty=%0d tx=%0d rz=%0d rx=%0d ry=%0d",
						$realtime, got.tz, got.ty, got.tx, got.rz, got.rx, got.ry);
				return;
			end
			want = axes_due.pop_front();
			if (got.tz !== want.tz || got.ty !== want.ty || got.tx !== want.tx ||
					got.rz !== want.rz || got.rx !== want.rx || got.ry !== want.ry) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN) begin
					$display("%0t: axes differ", $realtime);
					$display("  want tz=%0d ty=%0d tx=%0d rz=%0d rx=%0d ry=%0d",
						want.tz, want.ty, want.tx, want.rz, want.rx, want.ry);
					$display("  got  tz=%0d ty=%0d tx=%0d rz=%0d rx=%0d ry=%0d",
						got.tz, got.ty, got.tx, got.rz, got.rx, got.ry);
				end
			end
		endfunction
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic [SAMPLE_W-1:0] sample    = '0;
	logic                out_stall = 1'b0;
	logic                in_stall;
	logic                out_valid;
	logic signed [15:0]  trans_z;
	logic signed [14:0]  trans_y;
	logic signed [14:0]  trans_x;
	logic signed [15:0]  rot_z;
	logic signed [14:0]  rot_x;
	logic signed [14:0]  rot_y;

	hall_axes_calc calc = new();
	int            burst_left = 0;
	int            base_lvl [NUM_CH] = '{4095, 0, 2048, 2047, 4095, 0};

	six_axis_hall_offset_transform_top #(.AVG_SHIFT(AVG_SHIFT)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.trans_z   (trans_z),
		.trans_y   (trans_y),
		.trans_x   (trans_x),
		.rot_z     (rot_z),
		.rot_x     (rot_x),
		.rot_y     (rot_y)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// one item; a new burst opens with a random gap, long bursts give idle-free stretches
	task automatic push_sample(logic [SAMPLE_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
			                                          : $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		sample   <= v;
		do @(posedge clk); while (in_stall);
		calc.take_sample(v);
		burst_left--;
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		do @(posedge clk); while (calc.axes_due.size() != 0);
		burst_left = 0;
	endtask

	task automatic send_levels(input int lvl [NUM_CH], input int noise);
		int k, v;
		for (k = 0; k < FRAME_LEN; k++) begin
			v = lvl[k % NUM_CH];
			if (noise > 0)
				v = v + $urandom_range(0, 2 * noise) - noise;
			if (v < 0)
				v = 0;
			if (v > TOP_LVL)
				v = TOP_LVL;
			push_sample(SAMPLE_W'(v));
		end
	endtask

	task automatic send_random_frame(frame_kind_t kind);
		int lvl [NUM_CH];
		int k;
		for (k = 0; k < NUM_CH; k++) begin
			case (kind)
				FRAME_EXTREME:   lvl[k] = $urandom_range(0, 1) ? TOP_LVL : 0;
				FRAME_NEAR_BASE: lvl[k] = base_lvl[k];
				default:         lvl[k] = $urandom_range(0, TOP_LVL);
			endcase
		end
		if (kind == FRAME_NOISE) begin
			for (k = 0; k < FRAME_LEN; k++)
				push_sample(SAMPLE_W'($urandom_range(0, TOP_LVL)));
		end else if (kind == FRAME_EXTREME) begin
			send_levels(lvl, 0);
		end else begin
			send_levels(lvl, $urandom_range(1, 40));
		end
	endtask

	// receiver: checks each accepted result and drives a randomly redrawn stall pattern
	stall_kind_t stall_kind = STALL_NONE;
	int          kind_left  = 0;
	int          run_left   = 0;

	always @(posedge clk) begin
		axes_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{tz: trans_z, ty: trans_y, tx: trans_x, rz: rot_z, rx: rot_x, ry: rot_y};
			calc.match_axes(got);
		end
		if (kind_left == 0) begin
			stall_kind = stall_kind_t'($urandom_range(0, 3));
			kind_left  = $urandom_range(32, 256);
		end
		kind_left--;
		case (stall_kind)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default: begin
				if (run_left == 0) begin
					out_stall <= !out_stall;
					run_left = $urandom_range(1, 30);
				end
				run_left--;
			end
		endcase
	end

	initial begin
		int n;
		frame_kind_t kind;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// baseline frame, then full-scale offsets both ways and opposed pairs
		send_levels(base_lvl, 0);
		send_levels('{0, 0, 0, 0, 0, 0}, 0);
		send_levels('{4095, 4095, 4095, 4095, 4095, 4095}, 0);
		send_levels('{0, 4095, 4095, 0, 0, 4095}, 0);
		// alternating bit patterns per round: averages truncate to mid-scale
		for (n = 0; n < FRAME_LEN; n++)
			push_sample(((n / NUM_CH) % 2) ? 12'h555 : 12'hAAA);
		wait_results_done();

		for (n = 0; n < 36; n++) begin
			kind = frame_kind_t'($urandom_range(0, 3));
			send_random_frame(kind);
			if (n == 5 || n == 20 || $urandom_range(0, 7) == 0)
				wait_results_done();
		end

		wait_results_done();
		repeat (10) @(posedge clk);
		if (calc.mismatches == 0 && calc.axes_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[sim.f]
design/shot_pkg.sv
design/shot_front.sv
design/shot_queue.sv
design/shot_back.sv
design/six_axis_hall_offset_transform_top.sv
dv/tb.sv
